/* hdl/vdi_pkg.sv */
`timescale 1ns / 1ps

package vdi_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int COORD_W         = 32;
  localparam int KEY_W           = 2 * COORD_W;
  localparam int VINDEX_W        = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } vdi_state_t;

  // Search wave moving down the cell row.
  typedef struct packed {
    logic token;
    logic hit;
  } vdi_wave_t;

endpackage

/* hdl/vdi_cell.sv */
`timescale 1ns / 1ps

module vdi_cell #(
  parameter int IW         = 8,
  parameter int CW         = 9,
  parameter int CELL_INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [vdi_pkg::KEY_W-1:0] query,
  input  logic [CW-1:0]            count,
  input  logic                     wr_en,
  input  logic [IW-1:0]            wr_slot,
  input  vdi_pkg::vdi_wave_t       wave_in,
  input  logic [IW-1:0]            idx_in,
  output vdi_pkg::vdi_wave_t       wave_out,
  output logic [IW-1:0]            idx_out
);
  import vdi_pkg::*;

  localparam logic [IW-1:0] MY_IDX   = IW'(CELL_INDEX);
  localparam logic [CW-1:0] MY_COUNT = CW'(CELL_INDEX);

  logic [KEY_W-1:0] key;
  logic             match;

  assign match = (MY_COUNT < count) && (key == query);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_slot == MY_IDX)) begin
      key <= query;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out.token <= wave_in.token;
      wave_out.hit   <= wave_in.hit | (wave_in.token & match);
    end
  end

  always_ff @(posedge clk) begin
    idx_out <= wave_in.hit ? idx_in : MY_IDX;
  end

endmodule

/* hdl/vertex_dedup_indexer.sv */
`timescale 1ns / 1ps
// Channel   | Transaction    | tdata                     | tuser
// s_axis    | one vertex     | coord_x, coord_y          | pass_start, wipe
// m_axis    | one result     | vertex_index              | table_full, is_new
//
// Each vertex goes through these steps in order: a register launches the search wave,
// the wave walks the row of TABLE_DEPTH cells one cell per cycle, a capture register
// takes the result, and the commit writes the insert; the next vertex waits for it.
// Reset clears the entry count and the control state; keys are not cleared.
// A finished result waits in the output register while the next vertex is
// taken; the commit stalls only while that register is still occupied.

module vertex_dedup_indexer #(
  parameter int TABLE_DEPTH = vdi_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // coord_x, coord_y
  input  logic [1:0]  s_axis_tuser,   // pass_start, wipe
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // vertex_index
  output logic [1:0]  m_axis_tuser    // table_full, is_new
);
  import vdi_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  vdi_state_t       state;
  vdi_state_t       state_next;
  logic [KEY_W-1:0] query;
  logic [CW-1:0]    count;
  vdi_wave_t        launch;
  logic             res_hit;
  logic [IW-1:0]    res_idx;
  logic             accept;
  logic             commit_go;
  logic             wr_en;
  logic [IW-1:0]    wr_slot;
  logic [IW+VINDEX_W-1:0] idx_ext;
  logic [IW+VINDEX_W-1:0] slot_ext;

  vdi_wave_t        wave [0:TABLE_DEPTH];
  logic [IW-1:0]    idx  [0:TABLE_DEPTH];

  assign wave[0] = launch;
  assign idx[0]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    vdi_cell #(
      .IW        (IW),
      .CW        (CW),
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .query   (query),
      .count   (count),
      .wr_en   (wr_en),
      .wr_slot (wr_slot),
      .wave_in (wave[i]),
      .idx_in  (idx[i]),
      .wave_out(wave[i+1]),
      .idx_out (idx[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (wave[TABLE_DEPTH].token) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    commit_go     = (state == ST_COMMIT) && (!m_axis_tvalid || m_axis_tready);
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign wr_slot  = count[IW-1:0];
  assign wr_en    = commit_go && !res_hit && (count < DEPTH_C);
  assign idx_ext  = {{VINDEX_W{1'b0}}, res_idx};
  assign slot_ext = {{VINDEX_W{1'b0}}, wr_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= '0;
    end else begin
      launch.token <= accept;
      launch.hit   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && s_axis_tuser[0] && s_axis_tuser[1]) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEARCH && wave[TABLE_DEPTH].token) begin
      res_hit <= wave[TABLE_DEPTH].hit;
      res_idx <= idx[TABLE_DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      if (res_hit) begin
        m_axis_tdata <= idx_ext[VINDEX_W-1:0];
        m_axis_tuser <= 2'b00;
      end else if (count < DEPTH_C) begin
        m_axis_tdata <= slot_ext[VINDEX_W-1:0];
        m_axis_tuser <= 2'b01;
      end else begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 2'b10;
      end
    end
  end

endmodule
